// File: hdl/bvsoc_pkg.sv
// bvsoc_pkg: shared types, constants and the voltage/percent table of the
// battery state-of-charge estimator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bvsoc_pkg;

   // field widths
   localparam int ADC_W      = 12;
   localparam int RATIO_W    = 16;
   localparam int FRAC_W     = 8;
   localparam int AVG_W      = 24;
   localparam int MV_OUT_W   = 16;
   localparam int PCT_W      = 7;
   localparam int MV_W       = 13;

   // shared multiplier
   localparam int MUL_A_W    = AVG_W;
   localparam int MUL_B_W    = 16;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;

   // interpolation divider
   localparam int NUM_W      = AVG_W + PCT_W;
   localparam int QUOT_W     = PCT_W;
   localparam int BIT_W      = $clog2(QUOT_W);

   // table
   localparam int TABLE_POINTS = 11;
   localparam int SEG_W        = $clog2(TABLE_POINTS);

   // averaging weights, q0.16, sum to one
   localparam logic [MUL_B_W-1:0] W_OLD = 16'd62259;
   localparam logic [MUL_B_W-1:0] W_NEW = 16'd3277;
   localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W + 1)'(32768);

   localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
   localparam logic [PCT_W-1:0] PCT_EMPTY  = 7'd0;
   localparam logic [PCT_W-1:0] CHG_OFFSET = 7'd25;

   // configuration register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDER_RATIO       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_DETECT_EN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_ACTIVE_LEVEL = 2'd2;

   localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd8192;

   // table voltage point in mV, top point first
   function automatic logic [MV_W-1:0] tbl_mv(input logic [SEG_W-1:0] idx);
      logic [MV_W-1:0] mv;
      case (idx)
         4'd0:    mv = 13'd4150;
         4'd1:    mv = 13'd4060;
         4'd2:    mv = 13'd3970;
         4'd3:    mv = 13'd3900;
         4'd4:    mv = 13'd3840;
         4'd5:    mv = 13'd3790;
         4'd6:    mv = 13'd3760;
         4'd7:    mv = 13'd3730;
         4'd8:    mv = 13'd3710;
         4'd9:    mv = 13'd3650;
         4'd10:   mv = 13'd3300;
         default: mv = 13'd3300;
      endcase
      return mv;
   endfunction

   // table percentage point
   function automatic logic [PCT_W-1:0] tbl_pct(input logic [SEG_W-1:0] idx);
      logic [PCT_W-1:0] pct;
      case (idx)
         4'd0:    pct = 7'd100;
         4'd1:    pct = 7'd90;
         4'd2:    pct = 7'd80;
         4'd3:    pct = 7'd70;
         4'd4:    pct = 7'd60;
         4'd5:    pct = 7'd50;
         4'd6:    pct = 7'd40;
         4'd7:    pct = 7'd30;
         4'd8:    pct = 7'd20;
         4'd9:    pct = 7'd10;
         default: pct = 7'd0;
      endcase
      return pct;
   endfunction

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_SAMPLE,
      OP_MUL_OLD,
      OP_MUL_NEW,
      OP_SUM,
      OP_CLAMP,
      OP_SEARCH,
      OP_MUL_NUM,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_INTERP,
      OP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type        op;
      logic [BIT_W-1:0] div_bit;
   } dp_cmd_type;

   typedef struct packed {
      logic above;
      logic below;
      logic seg_hit;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hdl/battery_voltage_soc_estimator_core.sv
// battery_voltage_soc_estimator_core: top level, configuration registers
// and the controller/datapath pair. Uses bvsoc_pkg, bvsoc_ctrl, bvsoc_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Battery state-of-charge estimator. Each request transaction carries one
// calibrated adc reading (mV at the divider tap) and the charge pin level.
// The reading is scaled by divider_ratio (q4.12) into mV with 8 fraction
// bits, folded into a 0.95/0.05 exponential average (reseeded with the new
// sample after reset and whenever the charging decision changes), and mapped
// to a percentage by linear interpolation over an 11-point table from
// 4150 mV (100) down to 3300 mV (0), clamped at both ends; while charging
// 25 is taken off, saturating at 0. One response transaction per request.
// The block works on one request at a time: after acceptance a request
// passes the scale, average and clamp steps and then goes to the response
// register when the average lies outside the table, else first through the
// one-segment-per-cycle table search, the interpolation multiply on the
// shared 24x16 multiplier (used in sequence) and the restoring divider.
// The final step is held while the previous response waits for rsp_ready.
// A new request is accepted in the cycle after the previous one has moved
// into the response register, even while that response still waits for
// rsp_ready.
// Configuration writes are always accepted (csr_ready is tied high) and
// must only be issued while no request is in flight.
module battery_voltage_soc_estimator_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic [bvsoc_pkg::ADC_W-1:0]         req_adc_millivolts,
   input  wire logic                                req_charge_pin_level,
   input  wire logic                                req_external_charging,
   // response channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic [bvsoc_pkg::PCT_W-1:0]         rsp_level_percent,
   output      logic                                rsp_charging,
   output      logic [bvsoc_pkg::MV_OUT_W-1:0]      rsp_average_millivolts,
   // configuration write channel
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [bvsoc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [bvsoc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   logic [bvsoc_pkg::RATIO_W-1:0] divider_ratio_ff;
   logic                          charge_detect_enable_ff;
   logic                          charge_active_level_ff;

   // controller <-> datapath
   bvsoc_pkg::dp_cmd_type    cmd;
   bvsoc_pkg::dp_status_type status;

   // writes are registered directly, no back-pressure needed
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ratio_ff        <= bvsoc_pkg::RATIO_RESET;
         charge_detect_enable_ff <= 1'b0;
         charge_active_level_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bvsoc_pkg::CSR_DIVIDER_RATIO:
               divider_ratio_ff <= csr_wdata[bvsoc_pkg::RATIO_W-1:0];
            bvsoc_pkg::CSR_CHARGE_DETECT_EN:
               charge_detect_enable_ff <= csr_wdata[0];
            bvsoc_pkg::CSR_CHARGE_ACTIVE_LEVEL:
               charge_active_level_ff <= csr_wdata[0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // sequencer: walks scale, average, clamp, search, divide, finish
   bvsoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, running average state and the response register
   bvsoc_datapath u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .divider_ratio          (divider_ratio_ff),
      .charge_detect_enable   (charge_detect_enable_ff),
      .charge_active_level    (charge_active_level_ff),
      .req_adc_millivolts     (req_adc_millivolts),
      .req_charge_pin_level   (req_charge_pin_level),
      .req_external_charging  (req_external_charging),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_level_percent      (rsp_level_percent),
      .rsp_charging           (rsp_charging),
      .rsp_average_millivolts (rsp_average_millivolts)
   );

endmodule

`default_nettype wire

// File: hdl/bvsoc_ctrl.sv
// bvsoc_ctrl: sequencer of the estimator, steps the datapath through
// scale, average, clamp, segment search and divide. Uses bvsoc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvsoc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output      logic                    req_ready,
   input  wire bvsoc_pkg::dp_status_type status,
   output      bvsoc_pkg::dp_cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_SAMPLE,
      S_MUL_OLD,
      S_MUL_NEW,
      S_SUM,
      S_CLAMP,
      S_SEARCH,
      S_MUL_NUM,
      S_DIV_INIT,
      S_DIV_STEP,
      S_INTERP,
      S_FINISH
   } state_type;

   state_type                   state_ff;
   logic [bvsoc_pkg::BIT_W-1:0] bit_ff;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd.div_bit = bit_ff;
      unique case (state_ff)
         S_IDLE:       cmd.op = req_valid ? bvsoc_pkg::OP_LOAD : bvsoc_pkg::OP_NONE;
         S_MUL_SAMPLE: cmd.op = bvsoc_pkg::OP_MUL_SAMPLE;
         S_MUL_OLD:    cmd.op = bvsoc_pkg::OP_MUL_OLD;
         S_MUL_NEW:    cmd.op = bvsoc_pkg::OP_MUL_NEW;
         S_SUM:        cmd.op = bvsoc_pkg::OP_SUM;
         S_CLAMP:      cmd.op = bvsoc_pkg::OP_CLAMP;
         S_SEARCH:     cmd.op = bvsoc_pkg::OP_SEARCH;
         S_MUL_NUM:    cmd.op = bvsoc_pkg::OP_MUL_NUM;
         S_DIV_INIT:   cmd.op = bvsoc_pkg::OP_DIV_INIT;
         S_DIV_STEP:   cmd.op = bvsoc_pkg::OP_DIV_STEP;
         S_INTERP:     cmd.op = bvsoc_pkg::OP_INTERP;
         S_FINISH:     cmd.op = status.out_free ? bvsoc_pkg::OP_FINISH
                                                : bvsoc_pkg::OP_NONE;
         default:      cmd.op = bvsoc_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bit_ff   <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE:       if (req_valid) state_ff <= S_MUL_SAMPLE;
            S_MUL_SAMPLE: state_ff <= S_MUL_OLD;
            S_MUL_OLD:    state_ff <= S_MUL_NEW;
            S_MUL_NEW:    state_ff <= S_SUM;
            S_SUM:        state_ff <= S_CLAMP;
            S_CLAMP: begin
               // out of table range: percentage already set
               if (status.above || status.below) state_ff <= S_FINISH;
               else                              state_ff <= S_SEARCH;
            end
            S_SEARCH:     if (status.seg_hit) state_ff <= S_MUL_NUM;
            S_MUL_NUM:    state_ff <= S_DIV_INIT;
            S_DIV_INIT: begin
               bit_ff   <= bvsoc_pkg::BIT_W'(bvsoc_pkg::QUOT_W - 1);
               state_ff <= S_DIV_STEP;
            end
            S_DIV_STEP: begin
               if (bit_ff == '0) state_ff <= S_INTERP;
               else              bit_ff   <= bit_ff - 1'b1;
            end
            S_INTERP:     state_ff <= S_FINISH;
            S_FINISH:     if (status.out_free) state_ff <= S_IDLE;
            default:      state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: hdl/bvsoc_datapath.sv
// bvsoc_datapath: shared multiplier, running average, segment search,
// restoring divider and result register of the estimator. Uses bvsoc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvsoc_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire bvsoc_pkg::dp_cmd_type             cmd,
   output      bvsoc_pkg::dp_status_type          status,
   input  wire logic [bvsoc_pkg::RATIO_W-1:0]     divider_ratio,
   input  wire logic                              charge_detect_enable,
   input  wire logic                              charge_active_level,
   input  wire logic [bvsoc_pkg::ADC_W-1:0]       req_adc_millivolts,
   input  wire logic                              req_charge_pin_level,
   input  wire logic                              req_external_charging,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output      logic [bvsoc_pkg::PCT_W-1:0]       rsp_level_percent,
   output      logic                              rsp_charging,
   output      logic [bvsoc_pkg::MV_OUT_W-1:0]    rsp_average_millivolts
);

   localparam int AVG_W  = bvsoc_pkg::AVG_W;
   localparam int NUM_W  = bvsoc_pkg::NUM_W;
   localparam int PROD_W = bvsoc_pkg::PROD_W;
   localparam int PCT_W  = bvsoc_pkg::PCT_W;
   localparam int SEG_W  = bvsoc_pkg::SEG_W;
   localparam int FRAC_W = bvsoc_pkg::FRAC_W;

   // control state
   logic reseed_ff;
   logic prev_chg_ff;
   logic rsp_valid_ff;

   // payload
   logic [bvsoc_pkg::ADC_W-1:0] adc_ff;
   logic                        chg_ff;
   logic                        reseed_now_ff;
   logic [AVG_W-1:0]            sample_ff;
   logic [AVG_W-1:0]            avg_ff;
   logic [PROD_W-1:0]           prod_ff;
   logic [PROD_W-1:0]           acc_ff;
   logic [SEG_W-1:0]            seg_ff;
   logic [NUM_W-1:0]            rem_ff;
   logic [PCT_W-1:0]            quot_ff;
   logic [PCT_W-1:0]            pct_ff;
   logic [PCT_W-1:0]            out_pct_ff;
   logic                        out_chg_ff;
   logic [bvsoc_pkg::MV_OUT_W-1:0] out_mv_ff;

   logic                            chg_in;
   logic [bvsoc_pkg::MUL_A_W-1:0]   mul_a;
   logic [bvsoc_pkg::MUL_B_W-1:0]   mul_b;
   logic [SEG_W-1:0]                seg_next;
   logic [AVG_W-1:0]                hi_q8;
   logic [AVG_W-1:0]                lo_q8;
   logic [AVG_W-1:0]                top_q8;
   logic [AVG_W-1:0]                bot_q8;
   logic [AVG_W-1:0]                den;
   logic [NUM_W-1:0]                den_shift;
   logic [PCT_W-1:0]                dpct;
   logic [PROD_W:0]                 avg_sum;
   logic [PCT_W-1:0]                pct_adj;
   logic                            load_out;

   assign chg_in = charge_detect_enable ? (req_charge_pin_level == charge_active_level)
                                        : req_external_charging;

   assign seg_next = seg_ff + 1'b1;
   assign hi_q8    = AVG_W'({bvsoc_pkg::tbl_mv(seg_ff), FRAC_W'(0)});
   assign lo_q8    = AVG_W'({bvsoc_pkg::tbl_mv(seg_next), FRAC_W'(0)});
   assign top_q8   = AVG_W'({bvsoc_pkg::tbl_mv(SEG_W'(0)), FRAC_W'(0)});
   assign bot_q8   = AVG_W'({bvsoc_pkg::tbl_mv(SEG_W'(bvsoc_pkg::TABLE_POINTS - 1)),
                             FRAC_W'(0)});
   assign den      = hi_q8 - lo_q8;
   assign den_shift = NUM_W'(den) << cmd.div_bit;
   assign dpct     = bvsoc_pkg::tbl_pct(seg_ff) - bvsoc_pkg::tbl_pct(seg_next);

   // rounded weighted sum, weights add to 2^16 so bits above stay clear
   assign avg_sum  = {1'b0, acc_ff} + {1'b0, prod_ff} + bvsoc_pkg::ROUND_HALF;

   assign pct_adj  = !chg_ff ? pct_ff
                   : (pct_ff > bvsoc_pkg::CHG_OFFSET) ? pct_ff - bvsoc_pkg::CHG_OFFSET
                   : bvsoc_pkg::PCT_EMPTY;

   assign load_out = (cmd.op == bvsoc_pkg::OP_FINISH);

   assign status.above    = (avg_ff >= top_q8);
   assign status.below    = (avg_ff <= bot_q8);
   assign status.seg_hit  = (avg_ff <= hi_q8) && (avg_ff >= lo_q8);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // multiplier operand select
   always_comb begin
      case (cmd.op)
         bvsoc_pkg::OP_MUL_SAMPLE: begin
            mul_a = bvsoc_pkg::MUL_A_W'(adc_ff);
            mul_b = divider_ratio;
         end
         bvsoc_pkg::OP_MUL_OLD: begin
            mul_a = avg_ff;
            mul_b = bvsoc_pkg::W_OLD;
         end
         bvsoc_pkg::OP_MUL_NEW: begin
            mul_a = sample_ff;
            mul_b = bvsoc_pkg::W_NEW;
         end
         bvsoc_pkg::OP_MUL_NUM: begin
            mul_a = avg_ff - lo_q8;
            mul_b = bvsoc_pkg::MUL_B_W'(dpct);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reseed_ff    <= 1'b1;
         prev_chg_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == bvsoc_pkg::OP_LOAD) begin
            reseed_ff   <= 1'b0;
            prev_chg_ff <= chg_in;
         end
         if (load_out)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      unique case (cmd.op)
         bvsoc_pkg::OP_LOAD: begin
            adc_ff        <= req_adc_millivolts;
            chg_ff        <= chg_in;
            reseed_now_ff <= reseed_ff || (chg_in != prev_chg_ff);
         end
         bvsoc_pkg::OP_MUL_OLD: begin
            // q4.12 ratio, keep 8 fraction bits
            sample_ff <= prod_ff[AVG_W+4-1:4];
         end
         bvsoc_pkg::OP_MUL_NEW: acc_ff <= prod_ff;
         bvsoc_pkg::OP_SUM: begin
            avg_ff <= reseed_now_ff ? sample_ff : avg_sum[AVG_W+16-1:16];
         end
         bvsoc_pkg::OP_CLAMP: begin
            seg_ff <= '0;
            pct_ff <= status.above ? bvsoc_pkg::PCT_FULL : bvsoc_pkg::PCT_EMPTY;
         end
         bvsoc_pkg::OP_SEARCH: if (!status.seg_hit) seg_ff <= seg_next;
         bvsoc_pkg::OP_DIV_INIT: begin
            rem_ff  <= prod_ff[NUM_W-1:0];
            quot_ff <= '0;
         end
         bvsoc_pkg::OP_DIV_STEP: begin
            if (rem_ff >= den_shift) begin
               rem_ff                <= rem_ff - den_shift;
               quot_ff[cmd.div_bit] <= 1'b1;
            end
         end
         bvsoc_pkg::OP_INTERP: pct_ff <= bvsoc_pkg::tbl_pct(seg_next) + quot_ff;
         bvsoc_pkg::OP_FINISH: begin
            out_pct_ff <= pct_adj;
            out_chg_ff <= chg_ff;
            out_mv_ff  <= avg_ff[AVG_W-1:FRAC_W];
         end
         default: ;
      endcase
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_level_percent      = out_pct_ff;
   assign rsp_charging           = out_chg_ff;
   assign rsp_average_millivolts = out_mv_ff;

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_chg_ff |-> out_pct_ff <= bvsoc_pkg::PCT_FULL)
      else $error("level percent above full scale");

   a_chg_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_chg_ff |->
         out_pct_ff <= bvsoc_pkg::PCT_FULL - bvsoc_pkg::CHG_OFFSET)
      else $error("charging offset not applied");

   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bvsoc_pkg::OP_SEARCH |-> seg_ff < SEG_W'(bvsoc_pkg::TABLE_POINTS - 1))
      else $error("segment search ran past the table");

   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.op == bvsoc_pkg::OP_INTERP |-> quot_ff <= dpct)
      else $error("interpolation quotient exceeds segment span");

endmodule

`default_nettype wire
